// File: hw/rtl/tlm_pkg.sv
// ----------------------------------------------------------------------------
// tlm_pkg
// Shared types and constants for the text layout metrics block.
// ----------------------------------------------------------------------------
package tlm_pkg;

   localparam int TLM_ACC_WIDTH = 24;
   localparam int CP_WIDTH      = 21;
   localparam int EXT_WIDTH     = 10;
   localparam int ORIGIN_WIDTH  = 7;
   localparam int OUT_WIDTH     = 23;

   localparam logic [CP_WIDTH-1:0]  CP_CR  = 21'd13;
   localparam logic [CP_WIDTH-1:0]  CP_LF  = 21'd10;
   localparam logic [CP_WIDTH-1:0]  CP_TAB = 21'd9;

   localparam logic [7:0]           LINE_SIZE_DEFAULT = 8'd16;
   localparam logic [15:0]          WRAP_WIDTH_DEFAULT = 16'd0;
   localparam logic [OUT_WIDTH-1:0] OUT_MAX = 23'h7FFFFF;
   // yadv + height peaks at 127 + 255
   localparam logic [EXT_WIDTH-1:0] EXT_MAX = 10'd382;

   typedef enum logic [0:0] {
      REG_LINE_SIZE  = 1'b0,
      REG_WRAP_WIDTH = 1'b1
   } tlm_reg_type;

   typedef struct packed {
      logic                last_char;
      logic                glyph_found;
      logic signed [7:0]   top_bearing;
      logic signed [7:0]   left_bearing;
      logic [7:0]          glyph_height;
      logic signed [7:0]   y_advance;
      logic signed [7:0]   x_advance;
      logic [CP_WIDTH-1:0] code_point;
   } tlm_item_type;

endpackage

// File: hw/rtl/text_layout_metrics.sv
// ----------------------------------------------------------------------------
// text_layout_metrics
// Measures a stream of decoded characters as a text box.
//
// Requests arrive on the req_ channel: one code point per beat with its glyph
// metrics in req_tdata, the glyph-found flag in req_tuser and the end of the
// string on req_tlast. Pen position, line extent, widest line and height are
// tracked per character; carriage return, line feed and tab move the pen, and
// a glyph passing the wrap width opens a new line. On the last character one
// result (origin, width, height) goes out on rsp_ and the running state clears.
// A request is held in an input register; from there the running-state registers
// and, for a last character, the result register are loaded together.
// Throughput: one request per cycle while not stalled; the running-state update
// is a single add, compare and saturate per accumulator between the two registers.
// When the receiver stalls, the result register holds and the block keeps
// taking requests until a further last character reaches the update stage.
// Reset clears the running state, sets line_size to 16 and wrap_width to 0.
// Registers (csr_, 4-byte stride): 0 line_size, 4 wrap_width.
// ----------------------------------------------------------------------------
module text_layout_metrics
   import tlm_pkg::*;
#(
   parameter int ACC_WIDTH = TLM_ACC_WIDTH
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   // code_point[20:0], x_advance[28:21], y_advance[36:29], glyph_height[44:37],
   // left_bearing[52:45], top_bearing[60:53], zero[63:61]
   input  logic [63:0] req_tdata,
   // glyph_found[0]
   input  logic        req_tuser,
   input  logic        req_tlast,
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // origin_x[6:0], origin_y[13:7], text_width[36:14], text_height[59:37],
   // zero[63:60]
   output logic [63:0] rsp_tdata,
   // configuration
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam logic [ACC_WIDTH-1:0] AccMax = {1'b0, {(ACC_WIDTH-1){1'b1}}};
   localparam logic [ACC_WIDTH-1:0] AccMin = {1'b1, {(ACC_WIDTH-1){1'b0}}};
   localparam logic [ACC_WIDTH-1:0] OutLim =
      (ACC_WIDTH >= OUT_WIDTH + 1) ? ACC_WIDTH'(OUT_MAX) : AccMax;

   // configuration
   logic [7:0]  line_size_ff;
   logic [15:0] wrap_width_ff;
   logic        csr_write;
   tlm_reg_type csr_reg;

   // input register
   tlm_item_type in_ff;
   logic         in_valid_ff;
   logic         stall;
   logic         proc;

   // running state
   logic [ACC_WIDTH-1:0]    line_width_ff,  line_width_in;
   logic [ACC_WIDTH-1:0]    text_y_ff,      text_y_in;
   logic [EXT_WIDTH-1:0]    line_extent_ff, line_extent_in;
   logic [ACC_WIDTH-1:0]    max_width_ff,   max_width_in;
   logic [ACC_WIDTH-1:0]    max_height_ff,  max_height_in;
   logic [ORIGIN_WIDTH-1:0] best_left_ff,   best_left_in;
   logic [ORIGIN_WIDTH-1:0] best_top_ff,    best_top_in;
   logic                    at_line_start_ff, at_line_start_in;
   logic                    on_first_row_ff,  on_first_row_in;

   // result register
   logic        rsp_valid_ff;
   logic [63:0] rsp_data_ff, rsp_data_in;

   // datapath
   logic [7:0]           size;
   logic [ACC_WIDTH:0]   xadv_ext;
   logic [ACC_WIDTH:0]   pen_sum;
   logic [ACC_WIDTH:0]   tab_sum;
   logic [ACC_WIDTH:0]   wrap_ext;
   logic [ACC_WIDTH:0]   ty_sum;
   logic [ACC_WIDTH-1:0] ty_newline;
   logic                 wrap_hit;
   logic [EXT_WIDTH-1:0] ext_cand;
   logic [EXT_WIDTH-1:0] ext_base;
   logic                 start_eff;
   logic                 first_eff;
   logic [ACC_WIDTH-1:0] lw_next, ty_next, mw_next, mh_next;
   logic [EXT_WIDTH-1:0] ext_next;
   logic [ACC_WIDTH:0]   th_sum;
   logic [ACC_WIDTH-1:0] tw_lim;
   logic [ACC_WIDTH:0]   th_lim;

   function automatic logic [ACC_WIDTH-1:0] sat_acc(input logic [ACC_WIDTH:0] s);
      logic [ACC_WIDTH-1:0] r;
      if (s[ACC_WIDTH] != s[ACC_WIDTH-1]) begin
         r = s[ACC_WIDTH] ? AccMin : AccMax;
      end else begin
         r = s[ACC_WIDTH-1:0];
      end
      return r;
   endfunction

   // ---------------------------------------------------------------- config
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_reg    = tlm_reg_type'(csr_paddr[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         line_size_ff  <= LINE_SIZE_DEFAULT;
         wrap_width_ff <= WRAP_WIDTH_DEFAULT;
      end else if (csr_write) begin
         unique case (csr_reg)
            REG_LINE_SIZE:  line_size_ff  <= csr_pwdata[7:0];
            REG_WRAP_WIDTH: wrap_width_ff <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_reg)
         REG_LINE_SIZE:  csr_prdata = {24'd0, line_size_ff};
         REG_WRAP_WIDTH: csr_prdata = {16'd0, wrap_width_ff};
         default:        csr_prdata = 32'd0;
      endcase
   end

   // ------------------------------------------------------------ handshake
   // Only a last character needs the result register free.
   assign stall      = in_valid_ff && in_ff.last_char && rsp_valid_ff && !rsp_tready;
   assign proc       = in_valid_ff && !stall;
   assign req_tready = !stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_ff.code_point   <= req_tdata[20:0];
         in_ff.x_advance    <= req_tdata[28:21];
         in_ff.y_advance    <= req_tdata[36:29];
         in_ff.glyph_height <= req_tdata[44:37];
         in_ff.left_bearing <= req_tdata[52:45];
         in_ff.top_bearing  <= req_tdata[60:53];
         in_ff.glyph_found  <= req_tuser;
         in_ff.last_char    <= req_tlast;
      end
   end

   // ---------------------------------------------------------- arithmetic
   assign size     = (line_size_ff == 8'd0) ? LINE_SIZE_DEFAULT : line_size_ff;
   assign xadv_ext = {{(ACC_WIDTH-7){in_ff.x_advance[7]}}, in_ff.x_advance};
   assign pen_sum  = {line_width_ff[ACC_WIDTH-1], line_width_ff} + xadv_ext;
   assign tab_sum  = {line_width_ff[ACC_WIDTH-1], line_width_ff}
                   + {{(ACC_WIDTH-8){1'b0}}, size, 1'b0};
   assign wrap_ext = {{(ACC_WIDTH-15){1'b0}}, wrap_width_ff};
   assign wrap_hit = (wrap_width_ff != 16'd0) && ($signed(pen_sum) > $signed(wrap_ext));
   assign ty_sum   = {1'b0, text_y_ff} + {{(ACC_WIDTH-7){1'b0}}, size};
   assign ty_newline = (ty_sum > {1'b0, AccMax}) ? AccMax : ty_sum[ACC_WIDTH-1:0];
   assign ext_cand = {{(EXT_WIDTH-8){in_ff.y_advance[7]}}, in_ff.y_advance}
                   + {{(EXT_WIDTH-8){1'b0}}, in_ff.glyph_height};

   always_comb begin
      lw_next          = line_width_ff;
      ty_next          = text_y_ff;
      ext_next         = line_extent_ff;
      best_left_in     = best_left_ff;
      best_top_in      = best_top_ff;
      at_line_start_in = at_line_start_ff;
      on_first_row_in  = on_first_row_ff;
      start_eff        = at_line_start_ff;
      first_eff        = on_first_row_ff;
      ext_base         = line_extent_ff;

      case (in_ff.code_point)
         CP_CR: begin
            lw_next          = '0;
            at_line_start_in = 1'b1;
         end
         CP_LF: begin
            lw_next          = '0;
            ty_next          = ty_newline;
            ext_next         = '0;
            at_line_start_in = 1'b1;
            on_first_row_in  = 1'b0;
         end
         CP_TAB: begin
            lw_next          = sat_acc(tab_sum);
            at_line_start_in = 1'b0;
         end
         default: begin
            if (in_ff.glyph_found) begin
               // a wrapping glyph opens the new line
               if (wrap_hit) begin
                  ty_next         = ty_newline;
                  start_eff       = 1'b1;
                  first_eff       = 1'b0;
                  ext_base        = '0;
                  on_first_row_in = 1'b0;
                  lw_next         = xadv_ext[ACC_WIDTH-1:0];
               end else begin
                  lw_next = sat_acc(pen_sum);
               end
               ext_next = ($signed(ext_cand) > $signed(ext_base)) ? ext_cand : ext_base;
               if (start_eff && ($signed(in_ff.left_bearing) > $signed({1'b0, best_left_ff}))) begin
                  best_left_in = in_ff.left_bearing[ORIGIN_WIDTH-1:0];
               end
               if (first_eff && ($signed(in_ff.top_bearing) > $signed({1'b0, best_top_ff}))) begin
                  best_top_in = in_ff.top_bearing[ORIGIN_WIDTH-1:0];
               end
            end
            at_line_start_in = 1'b0;
         end
      endcase

      mw_next = ($signed(lw_next) > $signed(max_width_ff)) ? lw_next : max_width_ff;
      mh_next = (ty_next > max_height_ff) ? ty_next : max_height_ff;

      tw_lim = (mw_next > OutLim) ? OutLim : mw_next;
      th_sum = {1'b0, mh_next} + (ACC_WIDTH+1)'(ext_next);
      th_lim = (th_sum > {1'b0, OutLim}) ? {1'b0, OutLim} : th_sum;

      rsp_data_in = {4'd0, OUT_WIDTH'(th_lim), OUT_WIDTH'(tw_lim),
                     best_top_in, best_left_in};

      line_width_in  = lw_next;
      text_y_in      = ty_next;
      line_extent_in = ext_next;
      max_width_in   = mw_next;
      max_height_in  = mh_next;

      // end of string: drop the running state
      if (in_ff.last_char) begin
         line_width_in    = '0;
         text_y_in        = '0;
         line_extent_in   = '0;
         max_width_in     = '0;
         max_height_in    = '0;
         best_left_in     = '0;
         best_top_in      = '0;
         at_line_start_in = 1'b1;
         on_first_row_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff    <= '0;
         text_y_ff        <= '0;
         line_extent_ff   <= '0;
         max_width_ff     <= '0;
         max_height_ff    <= '0;
         best_left_ff     <= '0;
         best_top_ff      <= '0;
         at_line_start_ff <= 1'b1;
         on_first_row_ff  <= 1'b1;
      end else if (proc) begin
         line_width_ff    <= line_width_in;
         text_y_ff        <= text_y_in;
         line_extent_ff   <= line_extent_in;
         max_width_ff     <= max_width_in;
         max_height_ff    <= max_height_in;
         best_left_ff     <= best_left_in;
         best_top_ff      <= best_top_in;
         at_line_start_ff <= at_line_start_in;
         on_first_row_ff  <= on_first_row_in;
      end
   end

   // -------------------------------------------------------------- result
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (proc && in_ff.last_char) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (proc && in_ff.last_char) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTHESIS
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (in_valid_ff && in_ff.last_char && rsp_tvalid && !rsp_tready))
      else $error("request stalled without a held result");

   a_last_gives_result: assert property (@(posedge clock) disable iff (reset)
      (proc && in_ff.last_char) |=> (rsp_tvalid && at_line_start_ff && on_first_row_ff
                                     && (line_width_ff == '0) && (max_height_ff == '0)))
      else $error("last character did not produce a result and clear state");

   a_totals_positive: assert property (@(posedge clock) disable iff (reset)
      !max_width_ff[ACC_WIDTH-1] && !max_height_ff[ACC_WIDTH-1] && !text_y_ff[ACC_WIDTH-1])
      else $error("width or height accumulator went negative");

   a_extent_range: assert property (@(posedge clock) disable iff (reset)
      line_extent_ff <= EXT_MAX)
      else $error("line extent out of range");
`endif

endmodule
